// File: hw/rtl/tqfp_pkg.sv
package tqfp_pkg;

  localparam logic [7:0] QUOTE_CHAR = 8'h22;
  localparam logic [7:0] ROW_SEP_RESET = 8'h0a;
  localparam logic [7:0] COL_SEP_RESET = 8'h09;

  localparam int CFG_INDEX_W = 8;

  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

  localparam cfg_index_t CFG_ROW_SEPARATOR = 8'd0;
  localparam cfg_index_t CFG_COLUMN_SEPARATOR = 8'd1;

  typedef struct packed {
    logic in_quotes;
    logic quote_pending;
    logic field_nonempty;
    logic row_has_cells;
  } parse_state_t;

  typedef struct packed {
    logic       emit;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       field_done;
    logic       row_done;
  } parse_result_t;

endpackage

// File: hw/rtl/tqfp_if.sv
interface tqfp_item_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_data;

  modport source (output valid, output in_byte, output end_of_data, input ready);
  modport sink (input valid, input in_byte, input end_of_data, output ready);
endinterface

interface tqfp_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       field_done;
  logic       row_done;

  modport source (
    output valid, output out_byte, output byte_valid, output field_done,
    output row_done, input ready
  );
  modport sink (
    input valid, input out_byte, input byte_valid, input field_done,
    input row_done, output ready
  );
endinterface

interface tqfp_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/tqfp_step.sv
module tqfp_step (
  input  tqfp_pkg::parse_state_t  st,
  input  logic [7:0]              in_byte,
  input  logic                    end_of_data,
  input  logic [7:0]              row_separator,
  input  logic [7:0]              column_separator,
  output tqfp_pkg::parse_state_t  st_next,
  output tqfp_pkg::parse_result_t res
);
  import tqfp_pkg::*;

  logic quoted;
  logic taken;

  always_comb begin
    st_next = st;
    res = '0;
    quoted = st.in_quotes;
    taken = 1'b0;
    if (end_of_data) begin
      if (st.field_nonempty) begin
        res.emit = 1'b1;
        res.field_done = 1'b1;
        res.row_done = 1'b1;
      end else if (st.row_has_cells) begin
        // trailing empty field is dropped, only the row closes
        res.emit = 1'b1;
        res.row_done = 1'b1;
      end
      st_next = '0;
    end else begin
      // a held quote is resolved by this byte
      if (st.quote_pending) begin
        st_next.quote_pending = 1'b0;
        if (in_byte == QUOTE_CHAR) begin
          res.emit = 1'b1;
          res.out_byte = in_byte;
          res.byte_valid = 1'b1;
          st_next.field_nonempty = 1'b1;
          taken = 1'b1;
        end else begin
          quoted = 1'b0;
          st_next.in_quotes = 1'b0;
        end
      end
      if (!taken) begin
        if (quoted) begin
          if (in_byte == QUOTE_CHAR) begin
            st_next.quote_pending = 1'b1;
          end else begin
            res.emit = 1'b1;
            res.out_byte = in_byte;
            res.byte_valid = 1'b1;
            st_next.field_nonempty = 1'b1;
          end
        end else if (in_byte == QUOTE_CHAR) begin
          if (!st.field_nonempty) begin
            st_next.in_quotes = 1'b1;
          end else begin
            res.emit = 1'b1;
            res.out_byte = in_byte;
            res.byte_valid = 1'b1;
          end
        end else if (in_byte == column_separator) begin
          res.emit = 1'b1;
          res.field_done = 1'b1;
          st_next.field_nonempty = 1'b0;
          st_next.row_has_cells = 1'b1;
        end else if (in_byte == row_separator) begin
          res.emit = 1'b1;
          res.field_done = 1'b1;
          res.row_done = 1'b1;
          st_next.field_nonempty = 1'b0;
          st_next.row_has_cells = 1'b0;
        end else begin
          res.emit = 1'b1;
          res.out_byte = in_byte;
          res.byte_valid = 1'b1;
          st_next.field_nonempty = 1'b1;
        end
      end
    end
  end

endmodule

// File: hw/rtl/tsv_quoted_field_parser_core.sv
// each result is registered, in the cycle after its input transaction
// throughput: one byte per cycle unless stalled; the state is four flag bits updated in one step
// an item that produces no result (opening or held quote, empty end of data) just updates state
// the next item is taken while a result waits, as long as the result register is free or drains
// reset (synchronous, active high) clears the parse flags and the result valid flag and
// loads the separators with newline and tab
module tsv_quoted_field_parser_core (
  input  logic          clk,
  input  logic          rst,
  tqfp_item_if.sink     item,
  tqfp_result_if.source result,
  tqfp_cfg_if.sink      cfg
);
  import tqfp_pkg::*;

  parse_state_t  st;
  parse_state_t  st_next;
  parse_result_t res;
  logic [7:0]    row_separator;
  logic [7:0]    column_separator;
  logic          res_valid;
  logic [7:0]    res_byte;
  logic          res_byte_valid;
  logic          res_field_done;
  logic          res_row_done;
  logic          accept;

  tqfp_step u_step (
    .st               (st),
    .in_byte          (item.in_byte),
    .end_of_data      (item.end_of_data),
    .row_separator    (row_separator),
    .column_separator (column_separator),
    .st_next          (st_next),
    .res              (res)
  );

  assign item.ready = !res_valid || result.ready;
  assign accept = item.valid && item.ready;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_separator <= ROW_SEP_RESET;
      column_separator <= COL_SEP_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_ROW_SEPARATOR:    row_separator <= cfg.data;
        CFG_COLUMN_SEPARATOR: column_separator <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (accept) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= res.emit;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res.emit) begin
      res_byte <= res.out_byte;
      res_byte_valid <= res.byte_valid;
      res_field_done <= res.field_done;
      res_row_done <= res.row_done;
    end
  end

  assign result.valid = res_valid;
  assign result.out_byte = res_byte;
  assign result.byte_valid = res_byte_valid;
  assign result.field_done = res_field_done;
  assign result.row_done = res_row_done;

  // a held quote only exists inside a quoted section
  a_pending_in_quotes: assert property (@(posedge clk) disable iff (rst)
    st.quote_pending |-> st.in_quotes)
    else $error("quote pending outside quoted section");

  // content bytes never carry field or row marks
  a_content_no_marks: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_byte_valid) |-> (!res_field_done && !res_row_done))
    else $error("content byte carries a field or row mark");

  // end of data leaves the parser clean
  a_eod_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && item.end_of_data) |=> (st == '0))
    else $error("state not cleared after end of data");

  // a field mark without row mark only comes from a column separator
  a_field_only_row_cells: assert property (@(posedge clk) disable iff (rst)
    (accept && res.emit && res.field_done && !res.row_done) |=> st.row_has_cells)
    else $error("field closed without row holding cells");

endmodule
